### sv/assert_macros.svh
// Assertion helper macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/rhss_pkg.sv
// ----------------------------------------------------------------------------
// rhss_pkg
// Shared types and constants for the ROM header score and select block.
// ----------------------------------------------------------------------------
package rhss_pkg;

  // Header position codes
  localparam logic [1:0] CAND_LOW  = 2'd0;
  localparam logic [1:0] CAND_HIGH = 2'd1;
  localparam logic [1:0] CAND_EXT  = 2'd2;
  localparam logic [1:0] CAND_NONE = 2'd3;

  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned SCORE_W = 5;

  // Header base addresses and the header span that must fit in the image
  localparam logic [SIZE_W-1:0] POS_LOW     = 24'h007fb0;
  localparam logic [SIZE_W-1:0] POS_HIGH    = 24'h00ffb0;
  localparam logic [SIZE_W-1:0] POS_EXT     = 24'h40ffb0;
  localparam logic [SIZE_W-1:0] HEADER_SPAN = 24'h000050;

  // Minimum stripped size for any header to exist
  localparam logic [SIZE_W-1:0] MIN_IMAGE   = 24'h008000;
  // Copier header length, detected as the image size modulo 0x8000
  localparam logic [14:0]       COPIER_LEN  = 15'd512;

  // One candidate's header fields
  typedef struct packed {
    logic [1:0]  candidate;
    logic [7:0]  map_mode;
    logic [15:0] checksum_complement;
    logic [15:0] checksum_word;
    logic [15:0] reset_vector;
    logic [7:0]  first_opcode;
  } item_t;

endpackage

### sv/rhss_item_if.sv
// ----------------------------------------------------------------------------
// rhss_item_if
// Candidate header request channel: valid/ready plus the header fields.
// ----------------------------------------------------------------------------
interface rhss_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  candidate;
  logic [7:0]  map_mode;
  logic [15:0] checksum_complement;
  logic [15:0] checksum_word;
  logic [15:0] reset_vector;
  logic [7:0]  first_opcode;

  modport source (
    output valid, candidate, map_mode, checksum_complement, checksum_word,
           reset_vector, first_opcode,
    input  ready
  );
  modport sink (
    input  valid, candidate, map_mode, checksum_complement, checksum_word,
           reset_vector, first_opcode,
    output ready
  );
endinterface

### sv/rhss_result_if.sv
// ----------------------------------------------------------------------------
// rhss_result_if
// Score result channel: valid/ready plus score and selection status.
// ----------------------------------------------------------------------------
interface rhss_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] candidate_score;
  logic       decision_valid;
  logic       header_found;
  logic [1:0] chosen_header;

  modport source (
    output valid, candidate_score, decision_valid, header_found, chosen_header,
    input  ready
  );
  modport sink (
    input  valid, candidate_score, decision_valid, header_found, chosen_header,
    output ready
  );
endinterface

### sv/rhss_cfg_if.sv
// ----------------------------------------------------------------------------
// rhss_cfg_if
// Configuration write channel for the image size register.
// ----------------------------------------------------------------------------
interface rhss_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] image_size;

  modport source (output valid, image_size, input ready);
  modport sink   (input valid, image_size, output ready);
endinterface

### sv/rhss_score.sv
// ----------------------------------------------------------------------------
// rhss_score
// Combinational plausibility score for one candidate header position.
// ----------------------------------------------------------------------------
module rhss_score (
  input  rhss_pkg::item_t                   item,
  input  logic [rhss_pkg::SIZE_W-1:0]       stripped_size,
  output logic [rhss_pkg::SCORE_W-1:0]      score
);

  // Opcode class weight of the first instruction
  function automatic logic signed [5:0] opcode_weight(input logic [7:0] op);
    logic signed [5:0] w;
    begin
      unique case (op)
        8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c: w = 6'sd8;
        8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf,
        8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22:       w = 6'sd4;
        8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc: w = -6'sd4;
        8'h00, 8'h02, 8'hdb, 8'h42, 8'hff:       w = -6'sd8;
        default:                                 w = 6'sd0;
      endcase
      opcode_weight = w;
    end
  endfunction

  logic [rhss_pkg::SIZE_W-1:0] limit;
  logic                        fits;
  logic [16:0]                 chk_sum;
  logic [7:0]                  map_masked;
  logic                        map_match;
  logic signed [5:0]           raw;
  logic [4:0]                  clamped;

  always_comb begin
    // Image must hold the whole header at this position
    unique case (item.candidate)
      rhss_pkg::CAND_LOW:  limit = rhss_pkg::POS_LOW  + rhss_pkg::HEADER_SPAN;
      rhss_pkg::CAND_HIGH: limit = rhss_pkg::POS_HIGH + rhss_pkg::HEADER_SPAN;
      rhss_pkg::CAND_EXT:  limit = rhss_pkg::POS_EXT  + rhss_pkg::HEADER_SPAN;
      default:             limit = '1;
    endcase
    fits = (stripped_size >= limit) && (item.candidate != rhss_pkg::CAND_NONE);

    // Checksum and complement must add to 0xffff with no wrap
    chk_sum = {1'b0, item.checksum_word} + {1'b0, item.checksum_complement};

    // Map mode, FastROM bit ignored
    map_masked = item.map_mode & 8'hef;
    map_match  = ((item.candidate == rhss_pkg::CAND_LOW)  && (map_masked == 8'h20)) ||
                 ((item.candidate == rhss_pkg::CAND_HIGH) && (map_masked == 8'h21));

    raw = opcode_weight(item.first_opcode)
        + ((chk_sum == 17'h0ffff) ? 6'sd4 : 6'sd0)
        + (map_match ? 6'sd2 : 6'sd0);

    // Clamp at zero
    clamped = raw[5] ? 5'd0 : raw[4:0];

    // Reset vector must point into ROM space
    if (!fits || !item.reset_vector[15]) begin
      score = '0;
    end else if ((item.candidate == rhss_pkg::CAND_EXT) && (clamped != 5'd0)) begin
      score = clamped + 5'd4;
    end else begin
      score = clamped;
    end
  end

endmodule

### sv/rom_header_score_select_top.sv
// ----------------------------------------------------------------------------
// rom_header_score_select_top
// Scores low, high and extended header candidates and keeps the best one.
// ----------------------------------------------------------------------------
// Feed the three candidates of one image in the order low, high, extended;
// each request returns one result two register stages later, and a new request
// is taken every cycle while results keep draining. The low candidate restarts
// the selection; the result of the extended candidate carries decision_valid
// and the final chosen_header, with ties going to the earlier candidate. Write
// image_size only while no request is in flight; a 512-byte copier header is
// recognised from the size and stripped before all size checks.
`include "assert_macros.svh"

module rom_header_score_select_top (
  input  logic               clk,
  input  logic               rst,
  rhss_item_if.sink          item,
  rhss_result_if.source      result,
  rhss_cfg_if.sink           cfg
);

  logic [rhss_pkg::SIZE_W-1:0]  image_size;
  logic [rhss_pkg::SIZE_W-1:0]  stripped_size;
  logic                         header_found;

  logic                         s1_valid;
  rhss_pkg::item_t              s1;
  logic                         adv;

  logic [rhss_pkg::SCORE_W-1:0] score;
  logic [rhss_pkg::SCORE_W-1:0] best_score;
  logic [rhss_pkg::SCORE_W-1:0] best_score_next;
  logic [1:0]                   best_position;
  logic [1:0]                   best_position_next;

  logic                         out_valid;
  logic [rhss_pkg::SCORE_W-1:0] out_score;
  logic                         out_decision;
  logic                         out_found;
  logic [1:0]                   out_chosen;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg.valid) begin
      image_size <= cfg.image_size;
    end
  end

  // Copier header strip
  always_comb begin
    if (image_size[14:0] == rhss_pkg::COPIER_LEN) begin
      stripped_size = image_size - rhss_pkg::SIZE_W'(rhss_pkg::COPIER_LEN);
    end else begin
      stripped_size = image_size;
    end
  end
  assign header_found = (stripped_size >= rhss_pkg::MIN_IMAGE);

  // Pipeline flow control
  assign adv        = !out_valid || result.ready;
  assign item.ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1.candidate           <= item.candidate;
      s1.map_mode            <= item.map_mode;
      s1.checksum_complement <= item.checksum_complement;
      s1.checksum_word       <= item.checksum_word;
      s1.reset_vector        <= item.reset_vector;
      s1.first_opcode        <= item.first_opcode;
    end
  end

  // Candidate scoring
  rhss_score u_score (
    .item          (s1),
    .stripped_size (stripped_size),
    .score         (score)
  );

  // Running best: low restarts, later candidates need a strictly higher score
  always_comb begin
    priority if (s1.candidate == rhss_pkg::CAND_LOW) begin
      best_score_next    = score;
      best_position_next = rhss_pkg::CAND_LOW;
    end else if ((s1.candidate != rhss_pkg::CAND_NONE) && (score > best_score)) begin
      best_score_next    = score;
      best_position_next = s1.candidate;
    end else begin
      best_score_next    = best_score;
      best_position_next = best_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score    <= '0;
      best_position <= rhss_pkg::CAND_LOW;
    end else if (s1_valid && adv) begin
      best_score    <= best_score_next;
      best_position <= best_position_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      out_score    <= score;
      out_decision <= (s1.candidate == rhss_pkg::CAND_EXT);
      out_found    <= header_found;
      out_chosen   <= best_position_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.candidate_score = out_score;
  assign result.decision_valid  = out_decision;
  assign result.header_found    = out_found;
  assign result.chosen_header   = out_chosen;

  // Checks
  `ASSERT_IMPL(a_no_header_zero_score, clk, rst, out_valid && !out_found, out_score == '0)
  `ASSERT_ALWAYS(a_best_pos_legal, clk, rst, best_position != rhss_pkg::CAND_NONE)
  `ASSERT_NEXT(a_low_restarts, clk, rst, s1_valid && adv && (s1.candidate == rhss_pkg::CAND_LOW), best_position == rhss_pkg::CAND_LOW)
  `ASSERT_IMPL(a_score_range, clk, rst, out_valid, out_score <= 5'd18)

endmodule

### bench/rhss_selection_checker.sv
// ----------------------------------------------------------------------------
// rhss_selection_checker
// Watches the header, result and size channels of the header score/select
// block, predicts each result from the accepted requests and compares them.
// ----------------------------------------------------------------------------
module rhss_selection_checker
  import rhss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rhss_item_if        item,
  rhss_result_if      result,
  rhss_cfg_if         cfg,
  output int unsigned awaiting,
  output int unsigned fail_count
);

  // Map mode layouts that earn the bonus; the FastROM bit is masked off
  localparam logic [7:0] LAYOUT_LOW   = 8'h20;
  localparam logic [7:0] LAYOUT_HIGH  = 8'h21;
  localparam logic [7:0] FASTROM_MASK = 8'hef;
  localparam logic [16:0] CSUM_MATCH  = 17'h0ffff;

  typedef struct packed {
    logic [4:0] score;
    logic       decided;
    logic       found;
    logic [1:0] chosen;
  } selection_t;

  // Shadow of the block's register and running best
  logic [SIZE_W-1:0]  size_reg;
  logic [SCORE_W-1:0] best_score;
  logic [1:0]         best_pos;
  selection_t         due_results[$];
  int unsigned        results_seen;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Image size with any copier header taken off
  function automatic logic [SIZE_W-1:0] usable_size(input logic [SIZE_W-1:0] sz);
    if (sz[14:0] == COPIER_LEN)
      return sz - {9'd0, COPIER_LEN};
    return sz;
  endfunction

  // Weight of the first instruction by opcode class
  function automatic int opcode_points(input logic [7:0] op);
    case (op)
      8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c: return 8;
      8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf,
      8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22: return 4;
      8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc: return -4;
      8'h00, 8'h02, 8'hdb, 8'h42, 8'hff: return -8;
      default: return 0;
    endcase
  endfunction

  // Clamped score of one candidate, extended bonus included
  function automatic logic [SCORE_W-1:0] header_score(input item_t h,
                                                      input logic [SIZE_W-1:0] usable);
    logic [SIZE_W-1:0] base;
    logic [16:0]       total;
    logic [7:0]        layout;
    int                pts;
    case (h.candidate)
      CAND_LOW:  base = POS_LOW;
      CAND_HIGH: base = POS_HIGH;
      default:   base = POS_EXT;
    endcase
    // header must lie inside the image, reset vector in the upper half
    if (usable < base + HEADER_SPAN) return '0;
    if (!h.reset_vector[15]) return '0;
    pts = opcode_points(h.first_opcode);
    // no wrap: the 17-bit sum must hit 0xffff exactly
    total = {1'b0, h.checksum_word} + {1'b0, h.checksum_complement};
    if (total == CSUM_MATCH) pts += 4;
    layout = h.map_mode & FASTROM_MASK;
    if (h.candidate == CAND_LOW && layout == LAYOUT_LOW) pts += 2;
    if (h.candidate == CAND_HIGH && layout == LAYOUT_HIGH) pts += 2;
    if (pts < 0) pts = 0;
    if (h.candidate == CAND_EXT && pts != 0) pts += 4;
    return pts[SCORE_W-1:0];
  endfunction

  // Scores a request and moves the running best; low restarts the selection
  function automatic selection_t predict_selection(input item_t h);
    selection_t         s;
    logic [SIZE_W-1:0]  usable;
    logic [SCORE_W-1:0] pts;
    usable = usable_size(size_reg);
    pts = '0;
    if (h.candidate != CAND_NONE) begin
      pts = header_score(h, usable);
      if (h.candidate == CAND_LOW) begin
        best_score = pts;
        best_pos   = CAND_LOW;
      end else if (pts > best_score) begin
        best_score = pts;
        best_pos   = h.candidate;
      end
    end
    s.score   = pts;
    s.decided = (h.candidate == CAND_EXT);
    s.found   = (usable >= MIN_IMAGE);
    s.chosen  = best_pos;
    return s;
  endfunction

  // Results are matched before new requests are queued
  always @(posedge clk) begin : watch
    item_t      h;
    selection_t got;
    selection_t want;
    if (rst) begin
      size_reg     = '0;
      best_score   = '0;
      best_pos     = CAND_LOW;
      results_seen = 0;
      fail_count   = 0;
      due_results.delete();
      awaiting <= 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.candidate_score, result.decision_valid,
                result.header_found, result.chosen_header};
        if (due_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = due_results.pop_front();
          if (got.score !== want.score)
            report($sformatf("result %0d candidate_score %0d, expected %0d",
                             results_seen, got.score, want.score));
          if (got.decided !== want.decided)
            report($sformatf("result %0d decision_valid %0b, expected %0b",
                             results_seen, got.decided, want.decided));
          if (got.found !== want.found)
            report($sformatf("result %0d header_found %0b, expected %0b",
                             results_seen, got.found, want.found));
          if (got.chosen !== want.chosen)
            report($sformatf("result %0d chosen_header %0d, expected %0d",
                             results_seen, got.chosen, want.chosen));
        end
        results_seen++;
      end
      if (item.valid && item.ready) begin
        h = '{item.candidate, item.map_mode, item.checksum_complement,
              item.checksum_word, item.reset_vector, item.first_opcode};
        due_results.push_back(predict_selection(h));
      end
      if (cfg.valid && cfg.ready)
        size_reg = cfg.image_size;
      awaiting <= due_results.size();
    end
  end

endmodule

### bench/rom_header_score_select_top_tb.sv
// ----------------------------------------------------------------------------
// rom_header_score_select_top_tb
// Drives header candidates and image sizes into the score/select block, with
// random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rom_header_score_select_top_tb;
  import rhss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned PHASE_ITEMS    = 40;
  localparam int unsigned RANDOM_PHASES  = 12;

  // Opcodes that carry a weight, used to bias the first instruction byte
  localparam logic [7:0] CLASSED_OPS [28] = '{
    8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c,
    8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf, 8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22,
    8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc,
    8'h00, 8'h02, 8'hdb, 8'h42, 8'hff
  };

  // Boundary image sizes: empty, copier only, around the low, high and
  // extended limits, with and without a copier header, and all ones
  localparam logic [SIZE_W-1:0] EDGE_SIZES [12] = '{
    24'h000000, 24'h000200, 24'h007fff, 24'h008000, 24'h008200, 24'h00ffff,
    24'h010000, 24'h010200, 24'h40ffff, 24'h410000, 24'h410200, 24'hffffff
  };

  logic clk;
  logic rst;
  bit   idle_on;
  int unsigned awaiting;
  int unsigned fail_count;
  int unsigned headers_sent;
  int unsigned sizes_loaded;
  int unsigned quiet_cycles;

  rhss_item_if   item_ch();
  rhss_result_if result_ch();
  rhss_cfg_if    cfg_ch();

  rom_header_score_select_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rhss_selection_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .awaiting   (awaiting),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic item_t make_header(input logic [1:0] cand, input logic [7:0] map,
                                        input logic [15:0] comp, input logic [15:0] sum,
                                        input logic [15:0] rv, input logic [7:0] op);
    return '{cand, map, comp, sum, rv, op};
  endfunction

  // Low or high layout byte, FastROM bit random
  function automatic logic [7:0] LAYOUT_PICK(input bit high_map);
    return {3'b001, 1'($urandom), 3'b000, high_map};
  endfunction

  // Mostly plausible header fields with random content
  function automatic item_t random_header(input logic [1:0] cand);
    item_t h;
    h.candidate = cand;
    case ($urandom_range(0, 4))
      0: h.map_mode = LAYOUT_PICK(0);
      1: h.map_mode = LAYOUT_PICK(1);
      default: h.map_mode = 8'($urandom);
    endcase
    h.checksum_word       = 16'($urandom);
    h.checksum_complement = ($urandom_range(0, 4) < 3) ? ~h.checksum_word : 16'($urandom);
    h.reset_vector        = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(16'h8000, 16'hffff))
                                                         : 16'($urandom);
    h.first_opcode        = ($urandom_range(0, 9) < 7) ? CLASSED_OPS[$urandom_range(0, 27)]
                                                        : 8'($urandom);
    return h;
  endfunction

  // Any bit pattern at all, candidate code 3 included
  function automatic item_t noise_header();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  // One header request; valid stays high into the next unless a gap is drawn
  task automatic offer_header(input item_t h);
    item_ch.valid               <= 1'b1;
    item_ch.candidate           <= h.candidate;
    item_ch.map_mode            <= h.map_mode;
    item_ch.checksum_complement <= h.checksum_complement;
    item_ch.checksum_word       <= h.checksum_word;
    item_ch.reset_vector        <= h.reset_vector;
    item_ch.first_opcode        <= h.first_opcode;
    do @(posedge clk); while (!item_ch.ready);
    headers_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop requests and wait until every result is back, then a short pause
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Size register write, only ever issued with the block drained
  task automatic load_image_size(input logic [SIZE_W-1:0] sz);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.image_size <= sz;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sizes_loaded++;
  endtask

  // Mostly whole low/high/extended sets, the rest partial sets and noise
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    logic [1:0]  cand;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        offer_header(random_header(CAND_LOW));
        offer_header(random_header(CAND_HIGH));
        offer_header(random_header(CAND_EXT));
        sent += 3;
      end else begin
        cand = 2'($urandom_range(0, 3));
        offer_header($urandom_range(0, 1) ? random_header(cand) : noise_header());
        sent += 1;
      end
    end
  endtask

  // Result side back-pressure in random bursts
  initial begin : result_stall
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 8);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any request moving on any channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [SIZE_W-1:0] sz;
    idle_on      = 1'b1;
    headers_sent = 0;
    sizes_loaded = 0;
    rst                         <= 1'b1;
    item_ch.valid               <= 1'b0;
    item_ch.candidate           <= CAND_LOW;
    item_ch.map_mode            <= '0;
    item_ch.checksum_complement <= '0;
    item_ch.checksum_word       <= '0;
    item_ch.reset_vector        <= '0;
    item_ch.first_opcode        <= '0;
    cfg_ch.valid                <= 1'b0;
    cfg_ch.image_size           <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: copier header stripped, every candidate fits
    load_image_size(24'h410200);
    // all-zero fields, reset vector in the lower half
    offer_header(make_header(CAND_LOW, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    // all-ones fields: negative weight clamps, sum without wrap misses
    offer_header(make_header(CAND_HIGH, 8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    // lowest upper-half vector, matching checksum, extended bonus
    offer_header(make_header(CAND_EXT, 8'h20, 16'h0000, 16'hffff, 16'h8000, 8'h78));
    // unused candidate code
    offer_header(make_header(CAND_NONE, 8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    // FastROM layouts still earn the bonus; high beats low
    offer_header(make_header(CAND_LOW, 8'h30, 16'h1234, 16'hedcb, 16'h8000, 8'hc2));
    offer_header(make_header(CAND_HIGH, 8'h31, 16'h00ff, 16'hff00, 16'hfffc, 8'h5c));
    offer_header(make_header(CAND_EXT, 8'h21, 16'h0000, 16'h0000, 16'h7fff, 8'h78));
    // high layout on the low header earns nothing; low wins
    offer_header(make_header(CAND_LOW, 8'h21, 16'h0000, 16'hffff, 16'h8000, 8'h18));
    offer_header(make_header(CAND_HIGH, 8'h21, 16'h0000, 16'h0000, 16'h8123, 8'h4c));
    offer_header(make_header(CAND_EXT, 8'h00, 16'h0000, 16'h0000, 16'h9000, 8'ha9));
    // negative classes with checksum and layout bonuses
    offer_header(make_header(CAND_LOW, 8'h20, 16'hff00, 16'h00ff, 16'h8000, 8'h40));
    offer_header(make_header(CAND_HIGH, 8'h21, 16'hff00, 16'h00ff, 16'hc000, 8'hdb));
    offer_header(make_header(CAND_EXT, 8'h21, 16'hff00, 16'h00ff, 16'hc000, 8'h60));
    // extended ahead of low, compared against the held best
    offer_header(make_header(CAND_EXT, 8'h00, 16'h0000, 16'h0000, 16'hc000, 8'he2));
    // ties go to the earlier candidate
    offer_header(make_header(CAND_LOW, 8'h00, 16'h0000, 16'h0000, 16'h8000, 8'h20));
    offer_header(make_header(CAND_HIGH, 8'h00, 16'h0000, 16'h0000, 16'h8000, 8'ha0));
    offer_header(make_header(CAND_EXT, 8'h00, 16'h0000, 16'h0000, 16'h8000, 8'h9c));
    // unclassed opcode, high ahead of low
    offer_header(make_header(CAND_HIGH, 8'h21, 16'h5555, 16'haaaa, 16'hffff, 8'h01));
    offer_header(make_header(CAND_LOW, 8'h30, 16'h5555, 16'haaaa, 16'hffff, 8'h6b));

    // Boundary sizes, then random ones; idling switched off at random
    foreach (EDGE_SIZES[i]) begin
      load_image_size(EDGE_SIZES[i]);
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(PHASE_ITEMS);
    end
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        sz = 24'($urandom);
      end else begin
        sz = 24'($urandom_range(24'h410000, 24'hffffff));
        if ($urandom_range(0, 2) == 0) sz[14:0] = COPIER_LEN;
      end
      load_image_size(sz);
      idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      run_phase(PHASE_ITEMS);
    end

    drain();
    $display("Sent %0d header candidates across %0d image size settings,", headers_sent,
             sizes_loaded);
    $display("with boundary sizes, copier headers and stalls on both sides.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
